// ===== sv/seat_bitmap_run_allocator_top_assert.svh =====
// Assertion macros for the slot allocator checker.
`ifndef SEAT_BITMAP_RUN_ALLOCATOR_TOP_ASSERT_SVH
`define SEAT_BITMAP_RUN_ALLOCATOR_TOP_ASSERT_SVH

// Implication checked on every rising clock edge while out of reset.
`define SBRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked while out of reset.
`define SBRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sbra_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot allocator package
// Shared sizes, request and status codes, and state encoding.
// ---------------------------------------------------------------------------
package sbra_pkg;
    localparam int MaxSlots  = 1024;
    localparam int WordBits  = 8;
    localparam int MapWords  = (MaxSlots + WordBits - 1) / WordBits;
    localparam int AddrW     = $clog2(MapWords);
    localparam int BitW      = $clog2(WordBits);
    localparam int SlotW     = $clog2(MaxSlots);
    localparam int CountW    = SlotW + 1;

    localparam logic [1:0] KIND_CHECK = 2'd0;
    localparam logic [1:0] KIND_CLAIM = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_TAKEN  = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;
    localparam logic [1:0] ST_NO_RUN = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SREAD, S_SWAIT, S_RREAD, S_RBIT,
        S_WREAD, S_WWAIT, S_WBIT, S_OUT
    } t_state;
endpackage

// ===== sv/seat_bitmap_run_allocator_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Seat bitmap run allocator
// First-fit slot allocator over a taken-slot bitmap held in one memory.
// ---------------------------------------------------------------------------
// Channel  Direction  Handshake            Fields
// in       input      i_valid / o_ready    kind, slot, run_length
// out      output     o_valid / i_ready    status, first_slot, free_count
// cfg      input      i_cfg_we             capacity
// A check or single claim reads its map word in S_SREAD and S_SWAIT, then S_OUT
// raises o_valid; a bad slot, a bad kind or a rejected run length goes straight to S_OUT.
// A run claim scans one slot per cycle in S_RBIT, with a read in S_RREAD at the
// start of each map word; a found run is then written back slot by slot through
// S_WREAD, S_WWAIT and S_WBIT.
// After reset or a capacity write a clearing pass over all 128 map words runs first.
// A result waits in the output register; the next request is taken the cycle after it leaves.
module seat_bitmap_run_allocator_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [10:0]                  i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_kind,
    input  logic [9:0]                   i_slot,
    input  logic [10:0]                  i_run_length,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [1:0]                   o_status,
    output logic [9:0]                   o_first_slot,
    output logic [10:0]                  o_free_count
);
    localparam int AW = sbra_pkg::AddrW;
    localparam int BW = sbra_pkg::BitW;
    localparam int CW = sbra_pkg::CountW;
    localparam int SW = sbra_pkg::SlotW;
    localparam int WB = sbra_pkg::WordBits;

    logic [WB-1:0] mem [sbra_pkg::MapWords];
    logic [WB-1:0] r_rdata;
    logic          n_we;
    logic [AW-1:0] n_waddr, n_raddr;
    logic [WB-1:0] n_wdata;

    sbra_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_cap, n_cap_eff, r_free, n_free;
    logic [CW-1:0] r_pos, n_pos, r_cnt, n_cnt, r_len, n_len;
    logic [1:0]    r_kind, n_kind, r_status, n_status;
    logic [SW-1:0] r_first, n_first;
    logic [WB-1:0] r_word, n_word;
    logic          r_ovalid, n_ovalid;
    logic          bitv;

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            mem[n_waddr] <= n_wdata;
        end
        r_rdata <= mem[n_raddr];
    end

    assign n_cap_eff = (i_cfg_wdata > CW'(sbra_pkg::MaxSlots))
                       ? CW'(sbra_pkg::MaxSlots) : i_cfg_wdata[CW-1:0];
    assign bitv = r_rdata[r_pos[BW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sbra_pkg::S_CLEAR;
            r_cap    <= CW'(sbra_pkg::MaxSlots);
            r_free   <= CW'(sbra_pkg::MaxSlots);
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else if (i_cfg_we) begin
            r_state  <= sbra_pkg::S_CLEAR;
            r_cap    <= n_cap_eff;
            r_free   <= n_cap_eff;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_free   <= n_free;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
        r_cnt    <= n_cnt;
        r_len    <= n_len;
        r_kind   <= n_kind;
        r_status <= n_status;
        r_first  <= n_first;
        r_word   <= n_word;
    end

    always_comb begin
        n_state  = r_state;
        n_free   = r_free;
        n_pos    = r_pos;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_kind   = r_kind;
        n_status = r_status;
        n_first  = r_first;
        n_word   = r_word;
        n_ovalid = r_ovalid;
        n_we     = 1'b0;
        n_waddr  = r_pos[BW+AW-1:BW];
        n_wdata  = r_word;
        n_raddr  = r_pos[BW+AW-1:BW];
        o_ready  = 1'b0;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            sbra_pkg::S_CLEAR: begin
                n_we    = 1'b1;
                n_waddr = r_pos[AW-1:0];
                n_wdata = '0;
                n_pos   = r_pos + 1'b1;
                if (r_pos == CW'(sbra_pkg::MapWords - 1)) begin
                    n_state = sbra_pkg::S_IDLE;
                end
            end
            sbra_pkg::S_IDLE: begin
                o_ready = !r_ovalid;
                if (i_valid && !r_ovalid) begin
                    n_kind   = i_kind;
                    n_len    = i_run_length;
                    n_first  = '0;
                    n_status = sbra_pkg::ST_OK;
                    n_cnt    = '0;
                    if (i_kind == sbra_pkg::KIND_RUN) begin
                        n_pos = '0;
                        if (i_run_length == '0 || i_run_length > r_cap) begin
                            n_status = sbra_pkg::ST_NO_RUN;
                            n_state  = sbra_pkg::S_OUT;
                        end else begin
                            n_state = sbra_pkg::S_RREAD;
                        end
                    end else begin
                        n_pos = {1'b0, i_slot};
                        if (i_kind == sbra_pkg::KIND_RSVD || {1'b0, i_slot} >= r_cap) begin
                            n_status = sbra_pkg::ST_RANGE;
                            n_state  = sbra_pkg::S_OUT;
                        end else begin
                            n_state = sbra_pkg::S_SREAD;
                        end
                    end
                end
            end
            sbra_pkg::S_SREAD: n_state = sbra_pkg::S_SWAIT;
            sbra_pkg::S_SWAIT: begin
                n_state = sbra_pkg::S_OUT;
                if (bitv) begin
                    n_status = sbra_pkg::ST_TAKEN;
                end else if (r_kind == sbra_pkg::KIND_CLAIM) begin
                    n_we    = 1'b1;
                    n_wdata = r_rdata | (WB'(1) << r_pos[BW-1:0]);
                    if (r_free != '0) begin
                        n_free = r_free - 1'b1;
                    end
                end
            end
            sbra_pkg::S_RREAD: n_state = sbra_pkg::S_RBIT;
            sbra_pkg::S_RBIT: begin
                if (bitv) begin
                    n_cnt = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (!bitv && r_cnt + 1'b1 == r_len) begin
                    n_first = SW'(r_pos + 1'b1 - r_len);
                    n_pos   = r_pos + 1'b1 - r_len;
                    n_cnt   = '0;
                    n_free  = (r_free >= r_len) ? r_free - r_len : '0;
                    n_state = sbra_pkg::S_WREAD;
                end else if (r_pos + 1'b1 >= r_cap) begin
                    n_status = sbra_pkg::ST_NO_RUN;
                    n_state  = sbra_pkg::S_OUT;
                end else begin
                    n_pos = r_pos + 1'b1;
                    if (r_pos[BW-1:0] == BW'(WB - 1)) begin
                        n_state = sbra_pkg::S_RREAD;
                    end
                end
            end
            sbra_pkg::S_WREAD: n_state = sbra_pkg::S_WWAIT;
            sbra_pkg::S_WWAIT: begin
                n_word  = r_rdata | (WB'(1) << r_pos[BW-1:0]);
                n_state = sbra_pkg::S_WBIT;
            end
            sbra_pkg::S_WBIT: begin
                n_we    = 1'b1;
                n_wdata = r_word;
                n_cnt   = r_cnt + 1'b1;
                n_pos   = r_pos + 1'b1;
                n_state = (r_cnt + 1'b1 == r_len) ? sbra_pkg::S_OUT : sbra_pkg::S_WREAD;
            end
            sbra_pkg::S_OUT: begin
                n_ovalid = 1'b1;
                n_state  = sbra_pkg::S_IDLE;
            end
            default: n_state = sbra_pkg::S_IDLE;
        endcase
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_status;
    assign o_first_slot = r_first;
    assign o_free_count = r_free;
endmodule

// ===== sv/sbra_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Slot allocator port checker
// Port-level checks on the allocator handshakes and results.
// ---------------------------------------------------------------------------
`include "seat_bitmap_run_allocator_top_assert.svh"
module sbra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_status,
    input logic [9:0]  o_first_slot,
    input logic [10:0] o_free_count
);
    logic out_held;
    logic out_failed;

    assign out_held   = o_valid && !i_ready && !i_cfg_we;
    assign out_failed = o_valid && (o_status != sbra_pkg::ST_OK);

    `SBRA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_valid && $stable(o_status))
    `SBRA_ASSERT_IMP(a_no_ready_when_full, i_clk, i_rst_n, o_valid, !o_ready)
    `SBRA_ASSERT_IMP(a_first_zero, i_clk, i_rst_n, out_failed, o_first_slot == 10'd0)
    `SBRA_ASSERT_IMP(a_free_bound, i_clk, i_rst_n, 1'b1, o_free_count <= 11'd1024)
endmodule

bind seat_bitmap_run_allocator_top sbra_checker u_sbra_checker (.*);
